[hdl/lsd_pkg.sv]
// lsd_pkg: shared types, codes and sizes of the lace size decoder
// used by lsd_div, lsd_dp, lsd_ctrl and block_lace_size_decoder; no dependencies
package lsd_pkg;

    localparam int LSD_MAX_LACES = 64;     // largest lace count accepted, 2 .. 256
    localparam int LSD_SIZE_W    = 32;     // block and lace size width
    localparam int LSD_CNT_W     = 9;      // lace count width
    localparam int LSD_ACC_W     = 57;     // varint with marker bit, up to eight bytes
    localparam int LSD_DIV_CW    = $clog2(LSD_SIZE_W);

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_XIPH  = 2'd1,
        MODE_FIXED = 2'd2,
        MODE_EBML  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_VARINT  = 2'd1,
        ERR_OVERRUN = 2'd2,
        ERR_COUNT   = 2'd3
    } t_err;

    // datapath register operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HDR,
        OP_BYTE,
        OP_XIPH,
        OP_EBML,
        OP_RAW_SIZE,
        OP_RAW_ADD,
        OP_BIAS
    } t_op;

    // what the output register is loaded with
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_SIZE,
        OUT_REST,
        OUT_FIXED,
        OUT_WHOLE,
        OUT_FAIL
    } t_out_sel;

    typedef struct packed {
        t_op      op;
        t_out_sel out_sel;
        t_err     code;
        logic     div_start;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  cnt_bad;
        logic  cnt_one;
        logic  hb_full;
        logic  first_zero;
        logic  byte_ff;
        logic  left_zero;
        logic  done_zero;
        logic  bias_fail;
        logic  over;
        logic  rest_next;
        logic  fix_last;
        logic  div_busy;
        logic  out_free;
    } t_stat;

endpackage

[hdl/lsd_div.sv]
// lsd_div: restoring divider, one quotient bit per cycle, for fixed lacing
// depends on lsd_pkg
module lsd_div
    import lsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [LSD_SIZE_W-1:0] i_dividend,
    input  logic [LSD_CNT_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [LSD_SIZE_W-1:0] o_quotient
);

    logic                  r_busy;
    logic [LSD_DIV_CW-1:0] r_cnt;
    logic [LSD_SIZE_W-1:0] r_q;
    logic [LSD_CNT_W-1:0]  r_rem;
    logic [LSD_CNT_W:0]    w_shift;
    logic                  w_take;

    assign w_shift = {r_rem, r_q[LSD_SIZE_W-1]};
    assign w_take  = (w_shift >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LSD_DIV_CW'(LSD_SIZE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[LSD_SIZE_W-2:0], w_take};
            if (w_take) begin
                r_rem <= LSD_CNT_W'(w_shift - {1'b0, i_divisor});
            end else begin
                r_rem <= w_shift[LSD_CNT_W-1:0];
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule

[hdl/lsd_dp.sv]
// lsd_dp: block registers, varint and size arithmetic, output register
// depends on lsd_pkg and lsd_div
module lsd_dp
    import lsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [1:0]            i_lacing_mode,
    input  logic [LSD_CNT_W-1:0]  i_lace_count,
    input  logic [LSD_SIZE_W-1:0] i_block_size,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic [7:0]            o_lace_index,
    output logic [LSD_SIZE_W-1:0] o_lace_size,
    output logic                  o_last,
    output logic [1:0]            o_error
);

    t_mode                 r_mode;
    logic [LSD_CNT_W-1:0]  r_total;
    logic [LSD_CNT_W-1:0]  r_done;
    logic [LSD_SIZE_W-1:0] r_bs;
    logic [LSD_SIZE_W-1:0] r_hb;
    logic [LSD_SIZE_W:0]   r_hs;       // header bytes plus emitted sizes
    logic [LSD_ACC_W-1:0]  r_accum;
    logic [LSD_SIZE_W-1:0] r_prev;
    logic [3:0]            r_left;
    logic [3:0]            r_len;
    logic [7:0]            r_byte;
    logic [LSD_ACC_W-1:0]  r_size;
    logic [LSD_ACC_W-1:0]  r_tmp;

    logic                  r_valid;
    logic [7:0]            r_out_index;
    logic [LSD_SIZE_W-1:0] r_out_size;
    logic                  r_out_last;
    t_err                  r_out_error;

    logic [5:0]            w_mark_pos;
    logic [LSD_ACC_W-1:0]  w_raw;
    logic [LSD_ACC_W-1:0]  w_bias;
    logic [LSD_ACC_W-1:0]  w_xiph_sum;
    logic [LSD_ACC_W:0]    w_need;
    logic [3:0]            w_first_len;
    logic                  w_div_busy;
    logic [LSD_SIZE_W-1:0] w_quotient;
    logic                  w_fix_last;
    logic                  w_out_free;

    // varint length from the leading zeros of the first byte
    function automatic logic [3:0] lead_len(input logic [7:0] b);
        logic [3:0] len;
        len = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                len = 4'(8 - i);
            end
        end
        return len;
    endfunction

    lsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_bs),
        .i_divisor  (r_total),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    assign w_first_len = lead_len(r_byte);
    assign w_mark_pos  = 6'(7 * r_len);
    assign w_raw       = r_accum & ~(LSD_ACC_W'(1) << w_mark_pos);
    assign w_bias      = (LSD_ACC_W'(1) << (w_mark_pos - 6'd1)) - LSD_ACC_W'(1);
    assign w_xiph_sum  = r_accum + LSD_ACC_W'(r_byte);
    assign w_need      = (LSD_ACC_W+1)'(r_hs) + {1'b0, r_size};
    assign w_fix_last  = (r_done == r_total - 1'b1);
    assign w_out_free  = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NONE;
            r_total <= '0;
            r_done  <= '0;
            r_bs    <= '0;
            r_hb    <= '0;
            r_hs    <= '0;
            r_accum <= '0;
            r_prev  <= '0;
            r_left  <= '0;
            r_len   <= '0;
        end else begin
            case (i_cmd.op)
                OP_HDR: begin
                    r_mode  <= t_mode'(i_lacing_mode);
                    r_total <= i_lace_count;
                    r_bs    <= i_block_size;
                    r_done  <= '0;
                    r_hb    <= '0;
                    r_hs    <= '0;
                    r_accum <= '0;
                    r_prev  <= '0;
                    r_left  <= '0;
                end
                OP_XIPH: begin
                    r_hb    <= r_hb + 1'b1;
                    r_hs    <= r_hs + 1'b1;
                    r_accum <= w_xiph_sum;
                end
                OP_EBML: begin
                    r_hb <= r_hb + 1'b1;
                    r_hs <= r_hs + 1'b1;
                    if (r_left == 4'd0) begin
                        r_len   <= w_first_len;
                        r_left  <= w_first_len - 4'd1;
                        r_accum <= LSD_ACC_W'(r_byte);
                    end else begin
                        r_left  <= r_left - 4'd1;
                        r_accum <= {r_accum[LSD_ACC_W-9:0], r_byte};
                    end
                end
                default: begin
                end
            endcase
            case (i_cmd.out_sel)
                OUT_SIZE: begin
                    r_hs    <= r_hs + r_size[LSD_SIZE_W:0];
                    r_prev  <= r_size[LSD_SIZE_W-1:0];
                    r_done  <= r_done + 1'b1;
                    r_accum <= '0;
                end
                OUT_REST, OUT_FIXED: begin
                    r_done <= r_done + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // scratch registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_BYTE:     r_byte <= i_data_byte;
            OP_XIPH:     r_size <= w_xiph_sum;
            OP_RAW_SIZE: r_size <= w_raw;
            OP_RAW_ADD:  r_tmp  <= LSD_ACC_W'(r_prev) + w_raw;
            OP_BIAS:     r_size <= r_tmp - w_bias;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_sel != OUT_NONE) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sel != OUT_NONE) begin
            r_out_index <= r_done[7:0];
            r_out_error <= ERR_OK;
            case (i_cmd.out_sel)
                OUT_SIZE: begin
                    r_out_size <= r_size[LSD_SIZE_W-1:0];
                    r_out_last <= 1'b0;
                end
                OUT_REST: begin
                    r_out_size <= LSD_SIZE_W'({1'b0, r_bs} - r_hs);
                    r_out_last <= 1'b1;
                end
                OUT_FIXED: begin
                    r_out_size <= w_quotient;
                    r_out_last <= w_fix_last;
                end
                OUT_WHOLE: begin
                    r_out_size <= r_bs;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_size  <= '0;
                    r_out_last  <= 1'b1;
                    r_out_error <= i_cmd.code;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.cnt_bad    = (r_total == '0) || (r_total > LSD_CNT_W'(LSD_MAX_LACES));
        o_stat.cnt_one    = (r_total == LSD_CNT_W'(1));
        o_stat.hb_full    = (r_hb >= r_bs);
        o_stat.first_zero = (r_left == 4'd0) && (r_byte == 8'h00);
        o_stat.byte_ff    = (r_byte == 8'hff);
        o_stat.left_zero  = (r_left == 4'd0);
        o_stat.done_zero  = (r_done == '0);
        o_stat.bias_fail  = (r_tmp < w_bias);
        o_stat.over       = (w_need > (LSD_ACC_W+1)'(r_bs));
        o_stat.rest_next  = ((LSD_CNT_W+1)'(r_done) + 2'd2 >= (LSD_CNT_W+1)'(r_total));
        o_stat.fix_last   = w_fix_last;
        o_stat.div_busy   = w_div_busy;
        o_stat.out_free   = w_out_free;
    end

    assign o_valid      = r_valid;
    assign o_lace_index = r_out_index;
    assign o_lace_size  = r_out_size;
    assign o_last       = r_out_last;
    assign o_error      = r_out_error;

endmodule

[hdl/lsd_ctrl.sv]
// lsd_ctrl: sequencer for header decode, size-header bytes and result emission
// depends on lsd_pkg
module lsd_ctrl
    import lsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_kind,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PARSE,
        S_HDR,
        S_WHOLE,
        S_DIV,
        S_FIX,
        S_BYTE,
        S_EVAR,
        S_EBIAS,
        S_CHK,
        S_EMIT,
        S_REST,
        S_FAIL
    } t_state;

    t_state r_state, n_state;
    t_err   r_code, n_code;
    logic   r_ready, n_ready;

    always_comb begin
        n_state         = r_state;
        n_code          = r_code;
        o_cmd.op        = OP_NONE;
        o_cmd.out_sel   = OUT_NONE;
        o_cmd.code      = r_code;
        o_cmd.div_start = 1'b0;
        unique case (r_state)
            S_IDLE, S_PARSE: begin
                if (i_valid) begin
                    if (!i_kind) begin
                        o_cmd.op = OP_HDR;
                        n_state  = S_HDR;
                    end else if (r_state == S_PARSE) begin
                        o_cmd.op = OP_BYTE;
                        n_state  = S_BYTE;
                    end
                end
            end
            S_HDR: begin
                if (i_stat.mode == MODE_NONE) begin
                    n_state = S_WHOLE;
                end else if (i_stat.cnt_bad) begin
                    n_code  = ERR_COUNT;
                    n_state = S_FAIL;
                end else if (i_stat.mode == MODE_FIXED) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_stat.cnt_one) begin
                    n_state = S_WHOLE;
                end else begin
                    n_state = S_PARSE;
                end
            end
            S_WHOLE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_sel = OUT_WHOLE;
                    n_state       = S_IDLE;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (i_stat.out_free) begin
                    o_cmd.out_sel = OUT_FIXED;
                    if (i_stat.fix_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BYTE: begin
                if (i_stat.hb_full) begin
                    n_code  = ERR_OVERRUN;
                    n_state = S_FAIL;
                end else if (i_stat.mode == MODE_XIPH) begin
                    o_cmd.op = OP_XIPH;
                    n_state  = S_CHK;
                end else if (i_stat.first_zero) begin
                    n_code  = ERR_VARINT;
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_EBML;
                    n_state  = S_EVAR;
                end
            end
            S_EVAR: begin
                if (!i_stat.left_zero) begin
                    n_state = S_PARSE;
                end else if (i_stat.done_zero) begin
                    o_cmd.op = OP_RAW_SIZE;
                    n_state  = S_CHK;
                end else begin
                    o_cmd.op = OP_RAW_ADD;
                    n_state  = S_EBIAS;
                end
            end
            S_EBIAS: begin
                if (i_stat.bias_fail) begin
                    n_code  = ERR_VARINT;
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_BIAS;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.over) begin
                    n_code  = ERR_OVERRUN;
                    n_state = S_FAIL;
                end else if (i_stat.mode == MODE_XIPH && i_stat.byte_ff) begin
                    n_state = S_PARSE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_sel = OUT_SIZE;
                    n_state       = i_stat.rest_next ? S_REST : S_PARSE;
                end
            end
            S_REST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_sel = OUT_REST;
                    n_state       = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.out_sel = OUT_FAIL;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE) || (n_state == S_PARSE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ERR_OK;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

[hdl/block_lace_size_decoder.sv]
// block_lace_size_decoder: lace size decoder top, lsd_ctrl sequencer plus lsd_dp datapath
// a header gives the whole block or an error after decode (none, single lace, bad count);
// fixed lacing runs the divider, then one size per cycle unless the output stalls
// a size-header byte holds the input: byte, varint, bias, overrun check, emit, rest
// synchronous active-low reset returns to idle, no block open, output register empty
// depends on lsd_pkg, lsd_ctrl, lsd_dp, lsd_div
module block_lace_size_decoder
    import lsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [1:0]  i_lacing_mode,
    input  logic [8:0]  i_lace_count,
    input  logic [31:0] i_block_size,
    input  logic [7:0]  i_data_byte,
    // result transaction channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_lace_index,
    output logic [31:0] o_lace_size,
    output logic        o_last,
    output logic [1:0]  o_error
);

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: accepts transactions only while idle or waiting for a size-header
    // byte; results wait in the datapath output register so a new transaction
    // can be taken while the last result is still unclaimed
    lsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    // datapath: header registers, xiph run sum, ebml varint and bias, fixed divider
    lsd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_lacing_mode (i_lacing_mode),
        .i_lace_count  (i_lace_count),
        .i_block_size  (i_block_size),
        .i_data_byte   (i_data_byte),
        .i_out_ready   (i_ready),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_lace_index  (o_lace_index),
        .o_lace_size   (o_lace_size),
        .o_last        (o_last),
        .o_error       (o_error)
    );

`ifndef SYNTHESIS
    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_sel != OUT_NONE) |-> w_stat.out_free)
        else $error("result loaded into a full output register");

    // an error result closes the block with a zero size
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error != ERR_OK)) |-> (o_last && (o_lace_size == '0)))
        else $error("error result not final or with nonzero size");

    // a header transaction always blocks the input for decode
    a_hdr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_kind) |=> !o_ready)
        else $error("input ready right after a header transaction");
`endif

endmodule

[verif/tb_top.sv]
// tb_top: self-checking bench for block_lace_size_decoder, a directed table then random blocks
// holds its own lace size decoder and checks every result transaction field by field
// depends on lsd_pkg and block_lace_size_decoder
module tb_top
    import lsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one result transaction as the decoder should produce it
    typedef struct packed {
        logic [7:0]  lace_idx;
        logic [31:0] lace_size;
        logic        last;
        t_err        err;
    } t_lace_result;

    // one row of the directed table; res is only used where typed is set
    typedef struct packed {
        logic         kind;
        t_mode        mode;
        logic [8:0]   cnt;
        logic [31:0]  bsize;
        logic [7:0]   data;
        logic         typed;
        t_lace_result res;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic        i_kind        = 1'b0;
    logic [1:0]  i_lacing_mode = 2'd0;
    logic [8:0]  i_lace_count  = 9'd0;
    logic [31:0] i_block_size  = 32'd0;
    logic [7:0]  i_data_byte   = 8'd0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [7:0]  o_lace_index;
    logic [31:0] o_lace_size;
    logic        o_last;
    logic [1:0]  o_error;

    // expected lace sizes, oldest first
    t_lace_result sizes_due[$];
    // what the last predicted transaction produced
    t_lace_result step_q[$];
    t_lace_result due_res;

    // predictor state
    t_mode       lm_mode;
    int          lm_total;
    int          lm_done;
    logic [31:0] lm_block;
    logic [31:0] lm_hdr;
    logic [63:0] lm_sum;
    logic [63:0] lm_accum;
    logic [63:0] lm_prev;
    int          lm_left;
    logic        lm_parsing = 1'b0;

    // idle percentages of sender and receiver for the current phase
    int src_gap_pct = 18;
    int dst_gap_pct = 86;

    int n_fail    = 0;
    int n_items   = 0;
    int n_results = 0;
    int hdr_count [4] = '{0, 0, 0, 0};

    // directed table: extremes, every mode and each special case
    t_stim_row directed_rows [0:24] = '{
        // payload byte with no block open: ignored
        '{1'b1, MODE_EBML,  9'h1ff, 32'hffff_ffff, 8'hff, 1'b0, '0},
        // no lacing: the whole block, empty and full size, count ignored
        '{1'b0, MODE_NONE,  9'd0,   32'd0,         8'h00, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_OK}},
        '{1'b0, MODE_NONE,  9'd256, 32'hffff_ffff, 8'hff, 1'b1,
          '{8'd0, 32'hffff_ffff, 1'b1, ERR_OK}},
        // bad lace counts
        '{1'b0, MODE_FIXED, 9'd0,   32'd1000,      8'h00, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_COUNT}},
        '{1'b0, MODE_XIPH,  9'd65,  32'd1000,      8'h00, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_COUNT}},
        '{1'b0, MODE_EBML,  9'h1ff, 32'hffff_ffff, 8'h00, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_COUNT}},
        // laced block with a single lace gives the whole block
        '{1'b0, MODE_XIPH,  9'd1,   32'd1234,      8'h00, 1'b1,
          '{8'd0, 32'd1234, 1'b1, ERR_OK}},
        // fixed lacing at the largest count and size
        '{1'b0, MODE_FIXED, 9'd64,  32'hffff_ffff, 8'h00, 1'b0, '0},
        // xiph run of 255 closed by 10, then a new header drops the open block
        '{1'b0, MODE_XIPH,  9'd4,   32'd1000,      8'h00, 1'b0, '0},
        '{1'b1, MODE_NONE,  9'd0,   32'd0,         8'hff, 1'b0, '0},
        '{1'b1, MODE_FIXED, 9'h1ff, 32'hffff_ffff, 8'd10, 1'b0, '0},
        '{1'b0, MODE_EBML,  9'd2,   32'd100,       8'hff, 1'b0, '0},
        // varint whose first byte is zero
        '{1'b1, MODE_NONE,  9'd0,   32'd0,         8'h00, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_VARINT}},
        // xiph sum beyond the block
        '{1'b0, MODE_XIPH,  9'd2,   32'd3,         8'h00, 1'b0, '0},
        '{1'b1, MODE_XIPH,  9'd2,   32'd3,         8'hff, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_OVERRUN}},
        // size-header byte with no room left in the block
        '{1'b0, MODE_XIPH,  9'd2,   32'd0,         8'h00, 1'b0, '0},
        '{1'b1, MODE_XIPH,  9'd2,   32'd0,         8'h00, 1'b1,
          '{8'd0, 32'd0, 1'b1, ERR_OVERRUN}},
        // ebml: one byte first size, one byte difference, two byte difference
        '{1'b0, MODE_EBML,  9'd4,   32'd500,       8'h00, 1'b0, '0},
        '{1'b1, MODE_EBML,  9'd4,   32'd500,       8'h81, 1'b0, '0},
        '{1'b1, MODE_EBML,  9'd4,   32'd500,       8'hbf, 1'b0, '0},
        '{1'b1, MODE_EBML,  9'd4,   32'd500,       8'h60, 1'b0, '0},
        '{1'b1, MODE_EBML,  9'd4,   32'd500,       8'h00, 1'b0, '0},
        // difference that drives the running size negative
        '{1'b0, MODE_EBML,  9'd3,   32'd100,       8'h00, 1'b0, '0},
        '{1'b1, MODE_EBML,  9'd3,   32'd100,       8'h85, 1'b0, '0},
        '{1'b1, MODE_EBML,  9'd3,   32'd100,       8'h80, 1'b1,
          '{8'd1, 32'd0, 1'b1, ERR_VARINT}}
    };

    block_lace_size_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_lacing_mode (i_lacing_mode),
        .i_lace_count  (i_lace_count),
        .i_block_size  (i_block_size),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_lace_index  (o_lace_index),
        .o_lace_size   (o_lace_size),
        .o_last        (o_last),
        .o_error       (o_error)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // prints one line per mismatch and counts all of them
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        n_fail++;
        $display("%0t mismatch: %s, wanted %0h, got %0h", $time, what, want, got);
    endtask

    function automatic void queue_lace(input int idx, input logic [63:0] size,
                                       input logic last, input t_err err);
        t_lace_result r;
        r.lace_idx  = idx[7:0];
        r.lace_size = size[31:0];
        r.last      = last;
        r.err       = err;
        step_q.push_back(r);
    endfunction

    // any error closes the block with a single zero-size result
    function automatic void abort_block(input t_err code);
        lm_parsing = 1'b0;
        queue_lace(lm_done, 64'd0, 1'b1, code);
    endfunction

    // predicts the lace sizes caused by one accepted input transaction
    function automatic void decode_lace_item(input logic kind, input t_mode mode,
                                             input logic [8:0] cnt,
                                             input logic [31:0] bsize,
                                             input logic [7:0] b);
        logic [63:0] size;
        logic [63:0] raw;
        logic [63:0] bias;
        int          p;
        int          len;
        int          i;
        step_q.delete();
        if (kind == 1'b0) begin
            lm_mode    = mode;
            lm_total   = int'(cnt);
            lm_block   = bsize;
            lm_done    = 0;
            lm_hdr     = 32'd0;
            lm_sum     = 64'd0;
            lm_accum   = 64'd0;
            lm_prev    = 64'd0;
            lm_left    = 0;
            lm_parsing = 1'b0;
            if (mode == MODE_NONE) begin
                queue_lace(0, 64'(bsize), 1'b1, ERR_OK);
            end else if (lm_total == 0 || lm_total > LSD_MAX_LACES) begin
                queue_lace(0, 64'd0, 1'b1, ERR_COUNT);
            end else if (mode == MODE_FIXED) begin
                for (i = 0; i < lm_total; i++) begin
                    queue_lace(i, 64'(bsize / 32'(cnt)), i == lm_total - 1, ERR_OK);
                end
            end else if (lm_total == 1) begin
                queue_lace(0, 64'(bsize), 1'b1, ERR_OK);
            end else begin
                lm_parsing = 1'b1;
            end
            return;
        end

        if (!lm_parsing) return;
        if (lm_hdr >= lm_block) begin
            abort_block(ERR_OVERRUN);
            return;
        end
        lm_hdr++;
        if (lm_mode == MODE_XIPH) begin
            // runs of 255 keep adding up
            lm_accum += 64'(b);
            if (64'(lm_hdr) + lm_sum + lm_accum > 64'(lm_block)) begin
                abort_block(ERR_OVERRUN);
                return;
            end
            if (b == 8'hff) return;
            size     = lm_accum;
            lm_accum = 64'd0;
        end else begin
            if (lm_left == 0) begin
                if (b == 8'h00) begin
                    abort_block(ERR_VARINT);
                    return;
                end
                // length from the position of the marker bit
                len = 1;
                while (!b[8 - len]) len++;
                lm_left  = len - 1;
                lm_accum = 64'(b);
            end else begin
                lm_accum = (lm_accum << 8) | 64'(b);
                lm_left--;
            end
            if (lm_left != 0) return;
            p = 63;
            while (p > 0 && !lm_accum[p]) p--;
            raw      = lm_accum ^ (64'd1 << p);
            lm_accum = 64'd0;
            if (lm_done == 0) begin
                size = raw;
            end else begin
                // signed difference biased by half the varint range
                bias = (64'd1 << (p - 1)) - 64'd1;
                if (lm_prev + raw < bias) begin
                    abort_block(ERR_VARINT);
                    return;
                end
                size = lm_prev + raw - bias;
            end
            if (64'(lm_hdr) + lm_sum + size > 64'(lm_block)) begin
                abort_block(ERR_OVERRUN);
                return;
            end
        end

        queue_lace(lm_done, size, 1'b0, ERR_OK);
        lm_sum  += size;
        lm_prev  = size;
        lm_done++;
        // the last lace takes whatever is left of the block
        if (lm_done + 1 >= lm_total) begin
            queue_lace(lm_done, 64'(lm_block) - 64'(lm_hdr) - lm_sum, 1'b1, ERR_OK);
            lm_done++;
            lm_parsing = 1'b0;
        end
    endfunction

    // drives one input transaction at the falling edge, waits for it to be taken,
    // then files what it should produce; a typed result replaces the prediction
    task automatic send_item(input logic kind, input logic [1:0] mode,
                             input logic [8:0] cnt, input logic [31:0] bsize,
                             input logic [7:0] b, input logic typed,
                             input t_lace_result typed_res);
        logic counted;
        while ($urandom_range(99) < src_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_lacing_mode <= mode;
        i_lace_count  <= cnt;
        i_block_size  <= bsize;
        i_data_byte   <= b;
        do @(posedge i_clk); while (!o_ready);
        // payload bytes with no block open do not count as stimulus
        counted = (kind == 1'b0) || lm_parsing;
        if (kind == 1'b0) hdr_count[mode]++;
        decode_lace_item(kind, t_mode'(mode), cnt, bsize, b);
        if (counted) n_items++;
        if (typed) begin
            sizes_due.push_back(typed_res);
        end else begin
            foreach (step_q[k]) sizes_due.push_back(step_q[k]);
        end
        @(negedge i_clk);
    endtask

    // unused fields carry random noise
    task automatic send_header(input logic [1:0] mode, input logic [8:0] cnt,
                               input logic [31:0] bsize);
        send_item(1'b0, mode, cnt, bsize, 8'($urandom), 1'b0, '0);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b1, 2'($urandom), 9'($urandom), $urandom, b, 1'b0, '0);
    endtask

    function automatic void append_varint(ref logic [7:0] q[$], input logic [63:0] v,
                                          input int len);
        logic [63:0] acc;
        int          k;
        acc = (64'd1 << (7 * len)) | v;
        for (k = len - 1; k >= 0; k--) q.push_back(acc[8 * k +: 8]);
    endfunction

    // sends a header sized to fit its size-header bytes, sometimes broken on purpose
    task automatic send_laced(input logic [1:0] mode, input int cnt, input logic [63:0] total,
                              ref logic [7:0] body[$]);
        logic [31:0] bsize;
        int          keep;
        bsize = 32'(body.size()) + total[31:0] + $urandom_range(300);
        // short block: overrun on the sums or on the header bytes
        if ($urandom_range(9) == 0) bsize = $urandom_range(32'(body.size()) + total[31:0]);
        // corrupted size byte
        if ($urandom_range(9) == 0) body[$urandom_range(body.size() - 1)] = 8'($urandom);
        // cut short, the next header drops the block
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(body.size() - 1);
            while (body.size() > keep) void'(body.pop_back());
        end
        send_header(mode, 9'(cnt), bsize);
        foreach (body[k]) send_byte(body[k]);
    endtask

    // one random block: mostly well-formed laced blocks with random sizes
    task automatic send_random_block();
        logic [7:0]  body[$];
        logic [63:0] v;
        logic [63:0] total;
        logic [63:0] raw;
        longint      prev;
        int          pick;
        int          cnt;
        int          len;
        int          d;
        int          k;
        pick  = $urandom_range(99);
        total = 64'd0;
        if (pick < 35) begin
            // xiph: each size as a run of 255 plus a closing byte
            cnt = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(2, 8);
            for (k = 0; k < cnt - 1; k++) begin
                v = 64'($urandom_range(600));
                total += v;
                while (v >= 64'd255) begin
                    body.push_back(8'hff);
                    v -= 64'd255;
                end
                body.push_back(v[7:0]);
            end
            send_laced(MODE_XIPH, cnt, total, body);
        end else if (pick < 70) begin
            // ebml: unsigned first size, then signed differences
            cnt = $urandom_range(2, 8);
            v   = 64'($urandom_range(400));
            len = (v < 64'd128) ? 1 : 2;
            if ($urandom_range(7) == 0) len = $urandom_range(len, 8);
            append_varint(body, v, len);
            total = v;
            prev  = longint'(v);
            for (k = 1; k < cnt - 1; k++) begin
                d   = int'($urandom_range(120)) - 60;
                len = ($urandom_range(7) == 0) ? $urandom_range(2, 8) : $urandom_range(1, 2);
                raw = 64'(longint'(d)) + ((64'd1 << (7 * len - 1)) - 64'd1);
                append_varint(body, raw, len);
                prev += d;
                if (prev > 0) total += 64'(prev);
            end
            send_laced(MODE_EBML, cnt, total, body);
        end else if (pick < 78) begin
            send_header(MODE_NONE, 9'($urandom), $urandom);
        end else if (pick < 86) begin
            cnt = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            send_header(MODE_FIXED, 9'(cnt),
                        ($urandom_range(3) == 0) ? $urandom_range(cnt * 4) : $urandom);
        end else if (pick < 91) begin
            // lace count out of range in a laced mode
            cnt = ($urandom_range(1) == 0) ? 0 : $urandom_range(65, 511);
            send_header(2'($urandom_range(1, 3)), 9'(cnt), $urandom);
        end else if (pick < 95) begin
            // single lace, then a stray byte that is ignored
            send_header(($urandom_range(1) == 0) ? MODE_XIPH : MODE_EBML, 9'd1, $urandom);
            send_byte(8'($urandom));
        end else begin
            // noise: random header and random bytes
            send_header(2'($urandom), 9'($urandom), $urandom_range(64));
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
    endtask

    // receiver backpressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= dst_gap_pct);
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sizes_due.size() == 0) begin
                report_mismatch("result with no lace size pending", 64'd0, 64'(o_lace_size));
            end else begin
                due_res = sizes_due.pop_front();
                n_results++;
                if (o_lace_index !== due_res.lace_idx)
                    report_mismatch("lace_index", 64'(due_res.lace_idx), 64'(o_lace_index));
                if (o_lace_size !== due_res.lace_size)
                    report_mismatch("lace_size", 64'(due_res.lace_size), 64'(o_lace_size));
                if (o_last !== due_res.last)
                    report_mismatch("last", 64'(due_res.last), 64'(o_last));
                if (o_error !== due_res.err)
                    report_mismatch("error", 64'(due_res.err), 64'(o_error));
            end
        end
    end

    // main sequence
    initial begin
        int base;
        int phase;
        // reset held at start, released at a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table under the first idling setting
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].kind, directed_rows[r].mode, directed_rows[r].cnt,
                      directed_rows[r].bsize, directed_rows[r].data,
                      directed_rows[r].typed, directed_rows[r].res);
        end

        // random blocks in three idling phases
        base = n_items;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_gap_pct = 18;
                    dst_gap_pct = 86;
                end
                1: begin
                    src_gap_pct = 86;
                    dst_gap_pct = 18;
                end
                default: begin
                    src_gap_pct = 0;
                    dst_gap_pct = 0;
                end
            endcase
            while (n_items < base + (phase + 1) * 75) send_random_block();
            // sender holds off until every lace size is back
            i_valid <= 1'b0;
            while (sizes_due.size() != 0) @(negedge i_clk);
        end

        // drain, then allow for the divider latency
        while (sizes_due.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (sizes_due.size() != 0)
            report_mismatch("lace sizes never delivered", 64'd0, 64'(sizes_due.size()));

        $display("covered %0d transactions: %0d none, %0d xiph, %0d fixed, %0d ebml headers",
                 n_items, hdr_count[MODE_NONE], hdr_count[MODE_XIPH],
                 hdr_count[MODE_FIXED], hdr_count[MODE_EBML]);
        $display("checked %0d lace sizes under sender, receiver and no backpressure",
                 n_results);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout: decoder stopped making progress");
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/lsd_pkg.sv
hdl/lsd_div.sv
hdl/lsd_dp.sv
hdl/lsd_ctrl.sv
hdl/block_lace_size_decoder.sv
verif/tb_top.sv
